>>> hdl/cleb_pkg.sv
package cleb_pkg;

  // Field widths of the item channels
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 7;

  // Operation codes; the two codes above OP_READ do nothing
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_FWD    = 3'd2;
  localparam logic [OP_W-1:0] OP_BWD    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  // Printable range and the byte that stands in for anything outside it
  localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'd126;
  localparam logic [CHAR_W-1:0] SUBST_CHAR = 8'd63;

  // Replace a non-printable byte with the substitute
  function automatic logic [CHAR_W-1:0] map_char(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] res;
    if (ch < PRINT_LOW || ch > PRINT_HIGH) begin
      res = SUBST_CHAR;
    end else begin
      res = ch;
    end
    return res;
  endfunction

endpackage

>>> hdl/cleb_if.sv
interface cleb_in_if;
  logic                        valid;
  logic                        ready;
  logic [cleb_pkg::OP_W-1:0]   op;
  logic [cleb_pkg::CHAR_W-1:0] char_in;
  logic [cleb_pkg::POS_W-1:0]  read_index;

  modport source (output valid, output op, output char_in, output read_index, input ready);
  modport sink   (input valid, input op, input char_in, input read_index, output ready);
endinterface

interface cleb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [cleb_pkg::CHAR_W-1:0] removed_char;
  logic [cleb_pkg::CHAR_W-1:0] read_char;
  logic [cleb_pkg::POS_W-1:0]  cursor_pos;
  logic [cleb_pkg::POS_W-1:0]  line_length;

  modport source (output valid, output ok, output removed_char, output read_char,
                  output cursor_pos, output line_length, input ready);
  modport sink   (input valid, input ok, input removed_char, input read_char,
                  input cursor_pos, input line_length, output ready);
endinterface

>>> hdl/cleb_line_ram.sv
module cleb_line_ram #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cleb_pkg::CHAR_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [cleb_pkg::CHAR_W-1:0] rd_data
);

  logic [cleb_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [cleb_pkg::CHAR_W-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/cursor_line_edit_buffer_core.sv
// Channel   Dir  Handshake          Payload
// in_item   in   valid/ready        op, char_in, read_index
// out_item  out  valid/ready        ok, removed_char, read_char, cursor_pos, line_length
//
// One item at a time; ready is high only while the sequencer is idle.
// Insert and delete shift the bytes between cursor and line end one byte per cycle
// through the single line RAM port pair; clear sweeps zeros through the whole RAM.
// Every item ends in the result state, which can wait on out_item.ready.
// After reset the block sweeps zeros through every RAM cell before ready rises.
// A result waits in the output register while the next item is accepted.
module cursor_line_edit_buffer_core #(
  parameter int LINE_SIZE = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  cleb_in_if.sink    in_item,
  cleb_out_if.source out_item
);

  localparam int AW = $clog2(LINE_SIZE);
  localparam int NW = $clog2(LINE_SIZE + 1);
  localparam int XW = ((AW > cleb_pkg::POS_W) ? AW : cleb_pkg::POS_W) + 1;
  localparam logic [AW-1:0] LAST   = AW'(LINE_SIZE - 1);
  localparam logic [AW-1:0] NEAR   = AW'(LINE_SIZE - 3);
  localparam logic [XW-1:0] SIZE_X = XW'(LINE_SIZE);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RDW, S_SHIFT, S_WCH, S_CLR, S_DONE
  } state_t;

  state_t                      state_r;
  logic [AW-1:0]               cur_r;
  logic [AW-1:0]               end_r;
  logic [cleb_pkg::OP_W-1:0]   op_r;
  logic [cleb_pkg::CHAR_W-1:0] ch_r;
  logic [AW-1:0]               src_r;
  logic [AW-1:0]               last_r;
  logic [AW-1:0]               ptr_r;
  logic [NW-1:0]               cnt_r;
  logic                        pend_r;
  logic                        up_r;
  logic                        res_ok_r;
  logic [cleb_pkg::CHAR_W-1:0] res_rm_r;
  logic [cleb_pkg::CHAR_W-1:0] res_rd_r;
  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [cleb_pkg::CHAR_W-1:0] out_rm_r;
  logic [cleb_pkg::CHAR_W-1:0] out_rd_r;
  logic [cleb_pkg::POS_W-1:0]  out_cur_r;
  logic [cleb_pkg::POS_W-1:0]  out_len_r;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [cleb_pkg::CHAR_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [cleb_pkg::CHAR_W-1:0] rd_data;

  logic [XW-1:0]               idx_x;
  logic                        idx_ok;
  logic [AW-1:0]               hi;
  logic [XW-1:0]               cur_x;
  logic [XW-1:0]               end_x;

  assign idx_x  = XW'(in_item.read_index);
  assign idx_ok = idx_x < SIZE_X;
  assign cur_x  = XW'(cur_r);
  assign end_x  = XW'(end_r);
  // Top of the insert shift: one past the end, held at the last cell
  assign hi     = (end_r == LAST) ? LAST : end_r + AW'(1);

  cleb_line_ram #(.DEPTH(LINE_SIZE)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Steer the RAM ports from the sequencer state
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = src_r;
    unique case (state_r)
      S_INIT, S_CLR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        rd_en   = in_item.valid;
        rd_addr = (in_item.op == cleb_pkg::OP_DELETE) ? cur_r - AW'(1) : idx_x[AW-1:0];
      end
      S_SHIFT: begin
        wr_en   = pend_r;
        wr_addr = up_r ? last_r + AW'(1) : last_r - AW'(1);
        wr_data = rd_data;
        rd_en   = (cnt_r != '0);
      end
      S_WCH: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = ch_r;
      end
      default: ;
    endcase
  end

  assign in_item.ready = (state_r == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      cur_r       <= '0;
      end_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      up_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // Sweep zeros through the store
        S_INIT, S_CLR: begin
          ptr_r <= ptr_r + AW'(1);
          if (ptr_r == LAST) begin
            ptr_r   <= '0;
            state_r <= (state_r == S_CLR) ? S_DONE : S_IDLE;
          end
        end
        // Take an item and decode it
        S_IDLE: begin
          if (in_item.valid) begin
            op_r     <= in_item.op;
            ch_r     <= cleb_pkg::map_char(in_item.char_in);
            res_ok_r <= 1'b0;
            res_rm_r <= '0;
            res_rd_r <= '0;
            state_r  <= S_DONE;
            unique case (in_item.op)
              cleb_pkg::OP_INSERT: begin
                if (cur_r != LAST) begin
                  if (cur_r <= NEAR) begin
                    up_r    <= 1'b1;
                    src_r   <= hi - AW'(1);
                    cnt_r   <= NW'(hi - cur_r);
                    pend_r  <= 1'b0;
                    state_r <= S_SHIFT;
                  end else begin
                    state_r <= S_WCH;
                  end
                end
              end
              cleb_pkg::OP_DELETE: begin
                if (cur_r != '0) begin
                  state_r <= S_RDW;
                end
              end
              cleb_pkg::OP_FWD: begin
                if (cur_r < end_r) begin
                  cur_r    <= cur_r + AW'(1);
                  res_ok_r <= 1'b1;
                end
              end
              cleb_pkg::OP_BWD: begin
                if (cur_r != '0) begin
                  cur_r    <= cur_r - AW'(1);
                  res_ok_r <= 1'b1;
                end
              end
              cleb_pkg::OP_CLEAR: begin
                cur_r    <= '0;
                end_r    <= '0;
                ptr_r    <= '0;
                res_ok_r <= 1'b1;
                state_r  <= S_CLR;
              end
              cleb_pkg::OP_READ: begin
                if (idx_ok) begin
                  state_r <= S_RDW;
                end
              end
              default: ;
            endcase
          end
        end
        // Capture the byte read; a delete then pulls the tail left
        S_RDW: begin
          res_ok_r <= 1'b1;
          if (op_r == cleb_pkg::OP_DELETE) begin
            res_rm_r <= rd_data;
            up_r     <= 1'b0;
            src_r    <= cur_r;
            cnt_r    <= NW'(end_r - cur_r) + NW'(1);
            pend_r   <= 1'b0;
            cur_r    <= cur_r - AW'(1);
            if (end_r != '0) begin
              end_r <= end_r - AW'(1);
            end
            state_r <= S_SHIFT;
          end else begin
            res_rd_r <= rd_data;
            state_r  <= S_DONE;
          end
        end
        // Move one byte per cycle: read the next source while writing the last
        S_SHIFT: begin
          if (cnt_r != '0) begin
            last_r <= src_r;
            src_r  <= up_r ? src_r - AW'(1) : src_r + AW'(1);
            cnt_r  <= cnt_r - NW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r  <= 1'b0;
            state_r <= up_r ? S_WCH : S_DONE;
          end
        end
        // Write the inserted byte and advance
        S_WCH: begin
          cur_r <= cur_r + AW'(1);
          if (end_r != LAST) begin
            end_r <= end_r + AW'(1);
          end
          res_ok_r <= 1'b1;
          state_r  <= S_DONE;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || out_item.ready) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_rm_r    <= res_rm_r;
            out_rd_r    <= res_rd_r;
            out_cur_r   <= cur_x[cleb_pkg::POS_W-1:0];
            out_len_r   <= end_x[cleb_pkg::POS_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.ok           = out_ok_r;
  assign out_item.removed_char = out_rm_r;
  assign out_item.read_char    = out_rd_r;
  assign out_item.cursor_pos   = out_cur_r;
  assign out_item.line_length  = out_len_r;

  // The cursor never passes the end of the line
  a_cur_le_end: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= end_r)
    else $error("cursor beyond line end");

  // An accepted item keeps the sequencer busy, so ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.valid && in_item.ready |=> !in_item.ready)
    else $error("ready stayed high after accept");

  // Shift writes stay at or above the cursor
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && pend_r |->
      (up_r && wr_addr > cur_r) || (!up_r && wr_addr >= cur_r))
    else $error("shift write below cursor");

  // A new result is loaded only from the result state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside result state");

endmodule
